FILE: hdl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants for the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int LOC_W   = 11;
    localparam int IDX_W   = 11;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = CHAR_W + ATTR_W;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int TAB_STOP = 8;

    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

    // register index taken from paddr[2]
    localparam logic REG_TEXT_ATTR = 1'b0;

    typedef struct packed {
        logic [1:0]        mode;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } t_item;

    typedef struct packed {
        logic [LOC_W-1:0]  cursor_location;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attribute;
    } t_result;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scroll;
        logic blank;
        logic blank_rst;
        logic cnt_clr;
        logic cnt_inc;
        logic emit;
        logic emit_read;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       need_scroll;
        logic       rd_ok;
        logic       cnt_last;
        logic       scroll_end;
    } t_dp_status;

endpackage

FILE: hdl/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text console: screen store of character/attribute cells with a cursor.
// Items are taken only while idle, then run in S_EXEC: put without scroll,
//   unused mode or out-of-range read emits there; read emits from S_RDWAIT;
//   clear blanks the store; a scrolling put copies rows up, blanks the last row.
// Reset: busy for a clearing pass over the store.
// Results are a one-cycle o_done strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module text_console_cursor_engine
    import tcce_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    output t_result           o_result,
    output logic              o_done,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [ATTR_W-1:0] r_attr;
    t_dp_cmd           cmd;
    t_dp_status        status;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= RESET_ATTR;
        end else if (cfg_wr && (paddr[2] == REG_TEXT_ATTR)) begin
            r_attr <= pwdata[ATTR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TEXT_ATTR) ? APB_DW'(r_attr) : '0;

    tcce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_status(status),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    tcce_datapath #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_item),
        .i_attr  (r_attr),
        .o_status(status),
        .o_result(o_result),
        .o_done  (o_done)
    );

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without prior work");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two result strobes in a row");

    a_no_cmd_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !(cmd.exec || cmd.scroll || cmd.blank))
        else $error("datapath command while idle");

endmodule

FILE: hdl/tcce_ram.sv
// ----------------------------------------------------------------------------
// tcce_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tcce_datapath.sv
// ----------------------------------------------------------------------------
// tcce_datapath
// Cursor registers, screen store, sweep counter and result register.
// ----------------------------------------------------------------------------
module tcce_datapath
    import tcce_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  t_item             i_item,
    input  logic [ATTR_W-1:0] i_attr,
    output t_dp_status        o_status,
    output t_result           o_result,
    output logic              o_done
);

    localparam int CELLS    = ROWS * COLUMNS;
    localparam int SCROLL_N = (ROWS - 1) * COLUMNS;
    localparam int AW       = $clog2(CELLS);
    localparam int CTW      = $clog2(CELLS + 1);
    localparam int CBW      = $clog2(COLUMNS);
    localparam int CNW      = $clog2(COLUMNS + TAB_STOP);
    localparam int RBW      = $clog2(ROWS);
    localparam int RNW      = $clog2(ROWS + 1);
    localparam int LW       = (AW > LOC_W) ? AW : LOC_W;

    t_item            r_item;
    logic [CBW-1:0]   r_col;
    logic [RBW-1:0]   r_row;
    logic [CTW-1:0]   r_cnt, n_cnt;
    t_result          r_res;
    logic             r_done;

    logic [CNW-1:0]   n_col;
    logic [RNW-1:0]   n_row;
    logic             need_scroll;
    logic [LW-1:0]    loc;
    logic [AW-1:0]    pos;
    logic             printable;
    logic             is_put;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;
    logic [ATTR_W-1:0] blank_attr;

    assign is_put    = (r_item.mode == MODE_PUT);
    assign printable = (r_item.char_code >= CH_PRINT_LO) && (r_item.char_code <= CH_PRINT_HI);
    assign pos       = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);

    always_comb begin
        n_col       = CNW'(r_col);
        n_row       = RNW'(r_row);
        need_scroll = 1'b0;
        if (i_cmd.exec && is_put) begin
            case (r_item.char_code)
                CH_BS: begin
                    if (r_col != '0) begin
                        n_col = CNW'(r_col) - CNW'(1);
                    end
                end
                CH_CR: begin
                    n_col = '0;
                end
                CH_LF: begin
                    n_col = '0;
                    n_row = n_row + RNW'(1);
                end
                CH_TAB: begin
                    n_col = (CNW'(r_col) + CNW'(TAB_STOP)) & ~CNW'(TAB_STOP - 1);
                end
                default: begin
                    n_col = n_col + CNW'(1);
                end
            endcase
            if (n_col >= CNW'(COLUMNS)) begin
                n_col = '0;
                n_row = n_row + RNW'(1);
            end
            if (n_row >= RNW'(ROWS)) begin
                need_scroll = 1'b1;
                n_row       = RNW'(ROWS - 1);
            end
        end else if (i_cmd.exec && (r_item.mode == MODE_CLEAR)) begin
            n_col = '0;
            n_row = '0;
        end
    end

    assign loc = LW'(n_row) * LW'(COLUMNS) + LW'(n_col);

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.cnt_clr) begin
            n_cnt = '0;
        end else if (i_cmd.cnt_inc) begin
            n_cnt = r_cnt + CTW'(1);
        end
    end

    assign blank_attr = i_cmd.blank_rst ? RESET_ATTR : i_attr;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pos;
        ram_wdata = {i_attr, r_item.char_code};
        if (i_cmd.exec && is_put && printable) begin
            ram_we = 1'b1;
        end
        if (i_cmd.scroll) begin
            ram_we    = (r_cnt != '0);
            ram_waddr = r_cnt[AW-1:0] - AW'(1);
            ram_wdata = ram_rdata;
        end
        if (i_cmd.blank) begin
            ram_we    = 1'b1;
            ram_waddr = r_cnt[AW-1:0];
            ram_wdata = {blank_attr, CH_BLANK};
        end
    end

    // scroll reads one row ahead of the write
    assign ram_raddr = i_cmd.scroll ? (r_cnt[AW-1:0] + AW'(COLUMNS))
                                    : AW'(r_item.cell_index);

    tcce_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_col  <= n_col[CBW-1:0];
            r_row  <= n_row[RBW-1:0];
            r_cnt  <= n_cnt;
            r_done <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.emit) begin
            r_res.cursor_location <= loc[LOC_W-1:0];
            r_res.cell_char       <= i_cmd.emit_read ? ram_rdata[CHAR_W-1:0] : '0;
            r_res.cell_attribute  <= i_cmd.emit_read ? ram_rdata[CELL_W-1:CHAR_W] : '0;
        end
    end

    assign o_status.mode        = r_item.mode;
    assign o_status.need_scroll = need_scroll;
    assign o_status.rd_ok       = (LW'(r_item.cell_index) < LW'(CELLS));
    assign o_status.cnt_last    = (r_cnt == CTW'(CELLS - 1));
    assign o_status.scroll_end  = (r_cnt == CTW'(SCROLL_N));

    assign o_result = r_res;
    assign o_done   = r_done;

endmodule

FILE: hdl/tcce_ctrl.sv
// ----------------------------------------------------------------------------
// tcce_ctrl
// Sequencer for init sweep, item execution, scroll copy and blanking.
// ----------------------------------------------------------------------------
module tcce_ctrl
    import tcce_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_EXEC   = 6'b000100,
        S_RDWAIT = 6'b001000,
        S_SCROLL = 6'b010000,
        S_BLANK  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.blank     = 1'b1;
                o_cmd.blank_rst = 1'b1;
                o_cmd.cnt_inc   = 1'b1;
                if (i_status.cnt_last) begin
                    o_cmd.cnt_inc = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                unique case (i_status.mode)
                    MODE_PUT: begin
                        if (i_status.need_scroll) begin
                            o_cmd.cnt_clr = 1'b1;
                            n_state       = S_SCROLL;
                        end else begin
                            o_cmd.emit = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                    MODE_CLEAR: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = S_BLANK;
                    end
                    MODE_READ: begin
                        if (i_status.rd_ok) begin
                            n_state = S_RDWAIT;
                        end else begin
                            o_cmd.emit = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                    default: begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_RDWAIT: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_read = 1'b1;
                n_state         = S_IDLE;
            end
            S_SCROLL: begin
                o_cmd.scroll = 1'b1;
                if (i_status.scroll_end) begin
                    n_state = S_BLANK;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_BLANK: begin
                o_cmd.blank   = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_status.cnt_last) begin
                    o_cmd.cnt_inc = 1'b0;
                    o_cmd.emit    = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: sim/text_console_cursor_engine_tb.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine_tb
// Self-checking bench for the text console cursor engine. A behavioral
// screen/cursor model predicts every result; directed items cover the byte
// classes, reads and clear, then shaped random traffic (text lines, line
// feeds, tabs, backspaces, reads, noise) drives the cursor into wraps and
// scrolls under several attribute settings, with random start gaps in most runs.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_tb;
    import tcce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = COLUMNS_DEF * ROWS_DEF;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [APB_AW-1:0] ADDR_TEXT_ATTR = {REG_TEXT_ATTR, 2'b00};

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_item             i_item;
    t_result           o_result;
    logic              o_done;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // console model
    logic [CELL_W-1:0] screen_model [CELLS];
    int                cur_col;
    int                cur_row;
    logic [ATTR_W-1:0] attr_model;

    t_result console_replies_q [$];
    int      mismatch_count = 0;
    bit      gaps_on = 1'b1;

    text_console_cursor_engine dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_result (o_result),
        .o_done   (o_done),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void blank_cells(input int from, input int upto);
        for (int i = from; i < upto; i++) begin
            screen_model[i] = {attr_model, CH_BLANK};
        end
    endfunction

    function automatic void put_byte(input logic [CHAR_W-1:0] c);
        int pos;
        pos = cur_row * COLUMNS_DEF + cur_col;
        if (c == CH_BS) begin
            if (cur_col > 0) cur_col--;
        end else if (c == CH_CR) begin
            cur_col = 0;
        end else if (c == CH_LF) begin
            cur_col = 0;
            cur_row++;
        end else if (c == CH_TAB) begin
            cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
        end else begin
            cur_col++;
        end
        if (c >= CH_PRINT_LO && c <= CH_PRINT_HI) screen_model[pos] = {attr_model, c};
        if (cur_col >= COLUMNS_DEF) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= ROWS_DEF) begin
            for (int i = 0; i < (ROWS_DEF - 1) * COLUMNS_DEF; i++) begin
                screen_model[i] = screen_model[i + COLUMNS_DEF];
            end
            blank_cells((ROWS_DEF - 1) * COLUMNS_DEF, CELLS);
            cur_row = ROWS_DEF - 1;
        end
    endfunction

    function automatic t_result console_step(input t_item it);
        t_result r;
        r = '0;
        case (it.mode)
            MODE_PUT: begin
                put_byte(it.char_code);
            end
            MODE_CLEAR: begin
                blank_cells(0, CELLS);
                cur_col = 0;
                cur_row = 0;
            end
            MODE_READ: begin
                if (it.cell_index < CELLS) begin
                    r.cell_char      = screen_model[it.cell_index][CHAR_W-1:0];
                    r.cell_attribute = screen_model[it.cell_index][CELL_W-1:CHAR_W];
                end
            end
            default: ;
        endcase
        r.cursor_location = LOC_W'(cur_row * COLUMNS_DEF + cur_col);
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (console_replies_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual loc %0d char %0d attr %0d",
                         $time, o_result.cursor_location, o_result.cell_char,
                         o_result.cell_attribute);
                mismatch_count++;
            end else begin
                want = console_replies_q.pop_front();
                check_field("cursor_location", want.cursor_location,
                            o_result.cursor_location);
                check_field("cell_char", want.cell_char, o_result.cell_char);
                check_field("cell_attribute", want.cell_attribute, o_result.cell_attribute);
            end
        end
    end

    task automatic send_item(input t_item it);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(99) < 29) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        console_replies_q.push_back(console_step(it));
    endtask

    function automatic t_item make_item(input logic [1:0] mode, input logic [CHAR_W-1:0] c,
                                        input logic [IDX_W-1:0] idx);
        t_item it;
        it.mode       = mode;
        it.char_code  = c;
        it.cell_index = idx;
        return it;
    endfunction

    task automatic put(input logic [CHAR_W-1:0] c);
        send_item(make_item(MODE_PUT, c, IDX_W'($urandom)));
    endtask

    task automatic read_cell(input logic [IDX_W-1:0] idx);
        send_item(make_item(MODE_READ, CHAR_W'($urandom), idx));
    endtask

    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (console_replies_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic program_attribute(input logic [ATTR_W-1:0] v);
        settle();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TEXT_ATTR;
        pwdata  <= APB_DW'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        attr_model = v;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("prdata", APB_DW'(attr_model), prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_reset_state();
        read_cell(IDX_W'(0));
        read_cell(IDX_W'(CELLS - 1));
        read_cell('1);
        send_item(make_item(MODE_UNUSED, '1, '1));
    endtask

    task automatic test_put_bytes();
        put(8'h41);
        put(CH_PRINT_HI);
        put(CH_BLANK);
        put(8'h00);
        put(8'h1F);
        put(8'h80);
        put(8'hFF);
        put(CH_BS);
        put(CH_BS);
        put(CH_CR);
        put(CH_TAB);
        put(CH_LF);
        put(CH_BS);
        read_cell(IDX_W'(0));
        read_cell(IDX_W'(1));
        read_cell(IDX_W'(2));
        read_cell(IDX_W'(3));
    endtask

    task automatic test_clear();
        send_item(make_item(MODE_CLEAR, CHAR_W'($urandom), IDX_W'($urandom)));
        read_cell(IDX_W'(0));
    endtask

    task automatic test_random_traffic(input int n);
        int sent;
        int kind;
        int len;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(90, 1) : $urandom_range(12);
                for (int k = 0; k < len; k++) begin
                    put(CHAR_W'($urandom_range(CH_PRINT_HI, CH_PRINT_LO)));
                end
                if ($urandom_range(4) != 0) put(CH_LF);
                else put(CH_CR);
                sent += len + 1;
            end else if (kind < 53) begin
                len = $urandom_range(8, 1);
                repeat (len) put(CH_LF);
                sent += len;
            end else if (kind < 61) begin
                len = $urandom_range(11, 1);
                repeat (len) put(CH_TAB);
                sent += len;
            end else if (kind < 67) begin
                len = $urandom_range(6, 1);
                repeat (len) put(CH_BS);
                sent += len;
            end else if (kind < 80) begin
                len = $urandom_range(4, 1);
                repeat (len) begin
                    if ($urandom_range(9) == 0) read_cell(IDX_W'($urandom));
                    else read_cell(IDX_W'($urandom_range(CELLS - 1)));
                end
                sent += len;
            end else if (kind < 81) begin
                send_item(make_item(MODE_CLEAR, CHAR_W'($urandom), IDX_W'($urandom)));
                sent++;
            end else begin
                send_item(t_item'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        attr_model = RESET_ATTR;
        blank_cells(0, CELLS);
        cur_col = 0;
        cur_row = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        program_attribute(8'hFF);
        test_put_bytes();
        test_clear();

        program_attribute(8'h00);
        test_random_traffic(200);
        program_attribute(ATTR_W'($urandom));
        gaps_on = 1'b0;
        test_random_traffic(200);
        gaps_on = 1'b1;
        program_attribute(ATTR_W'($urandom));
        test_random_traffic(200);
        program_attribute(8'hFF);
        test_random_traffic(200);

        @(negedge i_clk);
        start <= 1'b0;
        while (console_replies_q.size() != 0) @(posedge i_clk);
        repeat (CELLS + 10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: text_console_cursor_engine.f
hdl/tcce_pkg.sv
hdl/tcce_ram.sv
hdl/tcce_datapath.sv
hdl/tcce_ctrl.sv
hdl/text_console_cursor_engine.sv
sim/text_console_cursor_engine_tb.sv
